@@ sv/tbsr_pkg.sv @@
`timescale 1ns / 1ps
package tbsr_pkg;

  // action codes
  localparam logic [2:0] ACT_PATTERN   = 3'd0;
  localparam logic [2:0] ACT_NAMETABLE = 3'd1;
  localparam logic [2:0] ACT_PALETTE   = 3'd2;
  localparam logic [2:0] ACT_SCROLL    = 3'd3;
  localparam logic [2:0] ACT_RENDER    = 3'd4;

  // configuration register indexes
  localparam int         CFG_IDX_W        = 1;
  localparam int         CFG_DATA_W       = 12;
  localparam logic [0:0] CFG_MIRROR       = 1'b0;
  localparam logic [0:0] CFG_PATTERN_BASE = 1'b1;

  // store geometry
  localparam int PATTERN_BYTES   = 4096;
  localparam int PATTERN_AW      = $clog2(PATTERN_BYTES);
  localparam int NAMETABLE_BYTES = 2048;
  localparam int NT_AW           = $clog2(NAMETABLE_BYTES);
  localparam int PALETTE_BYTES   = 32;
  localparam int PAL_AW          = $clog2(PALETTE_BYTES);

  // attribute block sits at offset 960 of each 1 KiB table
  localparam logic [3:0] ATTR_ROW_HI = 4'b1111;

  // coarse Y wrap points
  localparam logic [4:0] CY_WRAP_TOGGLE = 5'd29;
  localparam logic [4:0] CY_WRAP_PLAIN  = 5'd31;

  localparam int         LINE_PIXELS = 256;
  localparam logic [7:0] LINE_LAST   = 8'(LINE_PIXELS - 1);

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
  } pix_t;

endpackage

@@ sv/tile_background_scroll_renderer_core.sv @@
`timescale 1ns / 1ps
// channel | handshake                | payload
// cfg     | cfg_we                   | cfg_index, cfg_data
// in      | in_valid / in_ready      | action, address, data, pan_x, pan_y
// out     | out_valid / out_ready    | pixel, line_end
//
// One item per clock while in_ready is high. A render item goes nametable read, pattern read, palette
// read, then into an 8-deep result queue: out_valid rises once the pixel reaches the queue.
// Store writes are issued at the same stage as the matching read, so order holds.
// in_ready drops only when queued plus in-flight pixels fill the queue.
// Reset clears scroll state and config; store contents are undefined until written.
module tile_background_scroll_renderer_core import tbsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            action,
  input  logic [11:0]           address,
  input  logic [7:0]            data,
  input  logic [8:0]            pan_x,
  input  logic [8:0]            pan_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel,
  output logic                  line_end
);

  logic        mirror_vertical;
  logic [11:0] pattern_base;

  logic [14:0] scroll_address;
  logic [14:0] scroll_address_next;
  logic [2:0]  fine_x;
  logic [7:0]  pixel_column;

  logic accept;
  logic render;
  logic last;

  // stage 0 address build
  logic [8:0]       pos;
  logic [6:0]       hx;
  logic [4:0]       cx;
  logic [4:0]       cy;
  logic             phys;
  logic [NT_AW-1:0] tile_addr;
  logic [NT_AW-1:0] attr_addr;
  logic [4:0]       cy_next;

  // stage 1
  logic            s1_valid;
  logic [2:0]      s1_fy;
  logic            s1_cy1;
  logic            s1_cx1;
  logic [2:0]      s1_bit;
  logic            s1_last;
  logic            s1_pat_we;
  logic            s1_pal_we;
  logic [11:0]     s1_addr;
  logic [7:0]      s1_data;
  logic [7:0]      tile_q;
  logic [7:0]      attr_q;
  logic [PATTERN_AW-1:0] pat_lo_addr;
  logic [PATTERN_AW-1:0] pat_hi_addr;

  // stage 2
  logic              s2_valid;
  logic [1:0]        s2_quad;
  logic [2:0]        s2_bit;
  logic              s2_last;
  logic              s2_pal_we;
  logic [PAL_AW-1:0] s2_pal_addr;
  logic [7:0]        s2_data;
  logic [7:0]        lo_q;
  logic [7:0]        hi_q;
  logic [1:0]        colour;
  logic [PAL_AW-1:0] pal_raddr;

  // stage 3
  logic       s3_valid;
  logic       s3_last;
  logic [7:0] pal_q;

  logic [1:0]         inflight;
  logic [FIFO_AW:0]   fifo_count;
  logic [FIFO_AW+1:0] occupancy;
  pix_t               push_item;
  pix_t               head;

  assign accept = in_valid && in_ready;
  assign render = accept && (action == ACT_RENDER);
  assign last   = (pixel_column >= LINE_LAST);

  // ---------------- stage 0: nametable reads ----------------
  assign pos  = {1'b0, pixel_column} + {6'b0, fine_x};
  assign hx   = {1'b0, scroll_address[10], scroll_address[4:0]} + {1'b0, pos[8:3]};
  assign cx   = hx[4:0];
  assign cy   = scroll_address[9:5];
  assign phys = mirror_vertical ? hx[5] : scroll_address[11];

  assign tile_addr = {phys, cy, cx};
  assign attr_addr = {phys, ATTR_ROW_HI, cy[4:2], cx[4:2]};

  always_comb begin
    cy_next             = cy + 5'd1;
    scroll_address_next = scroll_address;
    if (scroll_address[14:12] != 3'd7) begin
      scroll_address_next[14:12] = scroll_address[14:12] + 3'd1;
    end else begin
      scroll_address_next[14:12] = 3'd0;
      priority if (cy == CY_WRAP_TOGGLE) begin
        scroll_address_next[9:5] = 5'd0;
        scroll_address_next[11]  = ~scroll_address[11];
      end else if (cy == CY_WRAP_PLAIN) begin
        scroll_address_next[9:5] = 5'd0;
      end else begin
        scroll_address_next[9:5] = cy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_vertical <= 1'b0;
      pattern_base    <= '0;
      scroll_address  <= '0;
      fine_x          <= '0;
      pixel_column    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIRROR:       mirror_vertical <= cfg_data[0];
          CFG_PATTERN_BASE: pattern_base    <= cfg_data[11:0];
          default:          ;
        endcase
      end
      if (accept) begin
        unique case (action)
          ACT_SCROLL: begin
            fine_x         <= pan_x[2:0];
            scroll_address <= {pan_y[2:0], pan_y[8], pan_x[8],
                               pan_y[7:3], pan_x[7:3]};
            pixel_column   <= '0;
          end
          ACT_RENDER: begin
            if (last) begin
              pixel_column   <= '0;
              scroll_address <= scroll_address_next;
            end else begin
              pixel_column <= pixel_column + 8'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // two copies so tile and attribute read in the same cycle
  tbsr_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_tile (
    .clk   (clk),
    .we    (accept && (action == ACT_NAMETABLE)),
    .waddr (address[NT_AW-1:0]),
    .wdata (data),
    .raddr (tile_addr),
    .rdata (tile_q)
  );

  tbsr_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_attr (
    .clk   (clk),
    .we    (accept && (action == ACT_NAMETABLE)),
    .waddr (address[NT_AW-1:0]),
    .wdata (data),
    .raddr (attr_addr),
    .rdata (attr_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_pat_we <= 1'b0;
      s1_pal_we <= 1'b0;
    end else begin
      s1_valid  <= render;
      s1_pat_we <= accept && (action == ACT_PATTERN);
      s1_pal_we <= accept && (action == ACT_PALETTE);
    end
  end

  always_ff @(posedge clk) begin
    s1_fy   <= scroll_address[14:12];
    s1_cy1  <= cy[1];
    s1_cx1  <= cx[1];
    s1_bit  <= ~pos[2:0];
    s1_last <= last;
    s1_addr <= address;
    s1_data <= data;
  end

  // ---------------- stage 1: pattern reads ----------------
  assign pat_lo_addr = PATTERN_AW'(pattern_base) + PATTERN_AW'({tile_q, 1'b0, s1_fy});
  assign pat_hi_addr = PATTERN_AW'(pattern_base) + PATTERN_AW'({tile_q, 1'b1, s1_fy});

  tbsr_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_lo (
    .clk   (clk),
    .we    (s1_pat_we),
    .waddr (PATTERN_AW'(s1_addr)),
    .wdata (s1_data),
    .raddr (pat_lo_addr),
    .rdata (lo_q)
  );

  tbsr_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_hi (
    .clk   (clk),
    .we    (s1_pat_we),
    .waddr (PATTERN_AW'(s1_addr)),
    .wdata (s1_data),
    .raddr (pat_hi_addr),
    .rdata (hi_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s2_pal_we <= 1'b0;
    end else begin
      s2_valid  <= s1_valid;
      s2_pal_we <= s1_pal_we;
    end
  end

  always_ff @(posedge clk) begin
    s2_quad     <= attr_q[{s1_cy1, s1_cx1, 1'b0} +: 2];
    s2_bit      <= s1_bit;
    s2_last     <= s1_last;
    s2_pal_addr <= s1_addr[PAL_AW-1:0];
    s2_data     <= s1_data;
  end

  // ---------------- stage 2: palette read ----------------
  assign colour    = {hi_q[s2_bit], lo_q[s2_bit]};
  // colour 0 always takes the backdrop entry
  assign pal_raddr = (colour == 2'd0) ? '0 : {s2_quad, colour};

  tbsr_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_pal (
    .clk   (clk),
    .we    (s2_pal_we),
    .waddr (s2_pal_addr),
    .wdata (s2_data),
    .raddr (pal_raddr),
    .rdata (pal_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_last <= s2_last;
  end

  // ---------------- stage 3: result queue ----------------
  assign push_item.pixel    = pal_q;
  assign push_item.line_end = s3_last;

  tbsr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid),
    .push_item (push_item),
    .pop       (out_valid && out_ready),
    .nonempty  (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  assign pixel    = head.pixel;
  assign line_end = head.line_end;

  assign inflight  = {1'b0, s1_valid} + {1'b0, s2_valid} + {1'b0, s3_valid};
  assign occupancy = {1'b0, fifo_count} + (FIFO_AW+2)'(inflight);
  assign in_ready  = (occupancy < (FIFO_AW+2)'(FIFO_DEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (fifo_count < (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_render_enters: assert property (@(posedge clk) disable iff (rst)
    render |=> s1_valid)
    else $error("accepted render item lost before stage 1");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> (s2_valid && $past(s1_last) == s2_last))
    else $error("stage 1 item did not reach stage 2");

  a_line_wrap: assert property (@(posedge clk) disable iff (rst)
    (render && last) |=> (pixel_column == 8'd0))
    else $error("pixel column did not wrap at line end");

  a_write_no_render: assert property (@(posedge clk) disable iff (rst)
    s1_pat_we |-> !s1_valid)
    else $error("pattern write and render share stage 1");
`endif

endmodule

@@ sv/tbsr_ram.sv @@
`timescale 1ns / 1ps
module tbsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tbsr_fifo.sv @@
`timescale 1ns / 1ps
module tbsr_fifo import tbsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pix_t             push_item,
  input  logic             pop,
  output logic             nonempty,
  output pix_t             head,
  output logic [FIFO_AW:0] count
);

  pix_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

endmodule
